/* rtl/core/zcrm_pkg.sv */
`default_nettype none
package zcrm_pkg;

  // Storage and field widths
  localparam int HISTORY_DEPTH = 32;
  localparam int SAMPLE_W      = 12;
  localparam int TIME_W        = 32;
  localparam int RPM_W         = 15;
  localparam int LEN_W         = 6;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int NCNT_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = RPM_W + IDX_W;
  localparam int DIV_W         = SUM_W;
  localparam int DCNT_W        = $clog2(DIV_W);

  // Arithmetic constants
  localparam int RPM_NUM       = 30000;
  localparam int LEN_RESET     = 1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_rpm;
    logic store_rpm;
    logic sum_step;
    logic div_avg;
    logic store_avg;
    logic emit;
  } zcrm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic crossing;
    logic div_done;
    logic multi;
    logic sum_last;
    logic out_free;
  } zcrm_stat_t;

endpackage
`default_nettype wire

/* rtl/core/zero_cross_rpm_meter_top.sv */
// Zero-crossing tachometer. Each request carries one 12-bit ADC sample and a
// millisecond timestamp and produces exactly one result: the latest rpm, the
// truncated mean of the newest n-1 rpms (0 unless this sample crossed and
// history_len is at least 2), a crossing flag and a zero-interval flag, n
// being history_len clamped to 1..32. Requests are handled one at a time. A
// sample without a crossing skips the divider; a crossing uses one
// shared 20-step restoring divider for 30000/interval and, when n is at least
// 2, the accumulator that reads one history entry per cycle and the same
// divider once more for the average. A finished result waits in an output
// register while the next request is taken. Write history_len through
// cfg_write only while no request is in flight; its reset value is 1.
`default_nettype none
module zero_cross_rpm_meter_top import zcrm_pkg::*; (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic                cfg_write,
  input  wire  logic [LEN_W-1:0]    cfg_data,
  input  wire  logic                in_valid,
  output logic                      in_ready,
  input  wire  logic [SAMPLE_W-1:0] sample,
  input  wire  logic [TIME_W-1:0]   now_ms,
  output logic                      out_valid,
  input  wire  logic                out_ready,
  output logic [RPM_W-1:0]          rpm,
  output logic [RPM_W-1:0]          rpm_average,
  output logic                      crossing,
  output logic                      zero_interval
);

  zcrm_cmd_t  cmd;
  zcrm_stat_t stat;

  zcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zcrm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rpm           (rpm),
    .rpm_average   (rpm_average),
    .crossing      (crossing),
    .zero_interval (zero_interval)
  );

endmodule
`default_nettype wire

/* rtl/core/zcrm_div.sv */
`default_nettype none
module zcrm_div import zcrm_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              start,
  input  wire  logic [DIV_W-1:0]  dividend,
  input  wire  logic [TIME_W-1:0] divisor,
  output logic                    done,
  output logic [DIV_W-1:0]        quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dsr;
  logic [DIV_W-1:0]  quo;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              take;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem, quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign take    = shifted >= {1'b0, dsr};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold operands and shift the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo <= {quo[DIV_W-2:0], take};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

/* rtl/core/zcrm_datapath.sv */
`default_nettype none
module zcrm_datapath import zcrm_pkg::*; (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  zcrm_cmd_t           cmd,
  output zcrm_stat_t                stat,
  input  wire  logic                cfg_write,
  input  wire  logic [LEN_W-1:0]    cfg_data,
  input  wire  logic [SAMPLE_W-1:0] sample,
  input  wire  logic [TIME_W-1:0]   now_ms,
  output logic                      out_valid,
  input  wire  logic                out_ready,
  output logic [RPM_W-1:0]          rpm,
  output logic [RPM_W-1:0]          rpm_average,
  output logic                      crossing,
  output logic                      zero_interval
);

  localparam logic signed [SAMPLE_W-1:0] DEAD_HI = SAMPLE_W'(1);
  localparam logic signed [SAMPLE_W-1:0] DEAD_LO = -SAMPLE_W'(1);

  logic [LEN_W-1:0]           history_len;
  logic signed [SAMPLE_W-1:0] prev_centered;
  logic [TIME_W-1:0]          last_time;
  logic [RPM_W-1:0]           hist [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0]        sample_r;
  logic [TIME_W-1:0]          now_r;
  logic                       cross_r;
  logic                       zero_r;
  logic [RPM_W-1:0]           avg_r;
  logic [SUM_W-1:0]           sum;
  logic [IDX_W-1:0]           idx;

  logic signed [SAMPLE_W-1:0] cur;
  logic                       is_cross;
  logic [TIME_W-1:0]          delta;
  logic [TIME_W-1:0]          delta_fix;
  logic [NCNT_W-1:0]          n_eff;
  logic [NCNT_W-1:0]          n_m1;
  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend;
  logic [TIME_W-1:0]          div_divisor;
  logic                       div_done;
  logic [DIV_W-1:0]           div_q;

  // Center the sample and test for a crossing outside the deadband
  assign cur      = $signed({~sample_r[SAMPLE_W-1], sample_r[SAMPLE_W-2:0]});
  assign is_cross = ((cur > DEAD_HI) && (prev_centered < DEAD_LO)) ||
                    ((cur < DEAD_LO) && (prev_centered > DEAD_HI));
  assign delta     = now_r - last_time;
  assign delta_fix = (delta == '0) ? TIME_W'(1) : delta;

  // Clamp the history length to 1..HISTORY_DEPTH
  always_comb begin
    if (history_len == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(history_len) > HISTORY_DEPTH) begin
      n_eff = NCNT_W'(HISTORY_DEPTH);
    end else begin
      n_eff = NCNT_W'(history_len);
    end
  end
  assign n_m1 = n_eff - 1'b1;

  // Shared divider: rpm from interval, then average from sum
  assign div_start    = cmd.div_rpm | cmd.div_avg;
  assign div_dividend = cmd.div_avg ? sum : DIV_W'(RPM_NUM);
  assign div_divisor  = cmd.div_avg ? TIME_W'(n_m1) : delta_fix;

  zcrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      history_len <= LEN_W'(LEN_RESET);
    end else if (cfg_write) begin
      history_len <= cfg_data;
    end
  end

  // Crossing tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_centered <= '0;
      last_time     <= '0;
    end else if (cmd.eval) begin
      prev_centered <= cur;
      if (is_cross) begin
        last_time <= now_r;
      end
    end
  end

  // History: entry 0 and entry 1 take the new rpm, the rest shift up to n-1
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (cmd.store_rpm) begin
      hist[0] <= div_q[RPM_W-1:0];
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        if (NCNT_W'(i) < n_eff) begin
          hist[i] <= (i == 1) ? div_q[RPM_W-1:0] : hist[i-1];
        end
      end
    end
  end

  // Request capture and per-request flags
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= sample;
      now_r    <= now_ms;
      cross_r  <= 1'b0;
      zero_r   <= 1'b0;
      avg_r    <= '0;
    end else begin
      if (cmd.eval && is_cross) begin
        cross_r <= 1'b1;
        zero_r  <= (delta == '0);
      end
      if (cmd.store_avg) begin
        avg_r <= div_q[RPM_W-1:0];
      end
    end
  end

  // Accumulate entries 1..n-1, one per cycle
  always_ff @(posedge clk) begin
    if (cmd.store_rpm) begin
      sum <= '0;
      idx <= IDX_W'(1);
    end else if (cmd.sum_step) begin
      sum <= sum + SUM_W'(hist[idx]);
      idx <= idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rpm           <= hist[0];
      rpm_average   <= avg_r;
      crossing      <= cross_r;
      zero_interval <= zero_r;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.crossing = is_cross;
    stat.div_done = div_done;
    stat.multi    = n_eff > NCNT_W'(1);
    stat.sum_last = idx == n_m1[IDX_W-1:0];
    stat.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

/* rtl/core/zcrm_ctrl.sv */
`default_nettype none
module zcrm_ctrl import zcrm_pkg::*; (
  input  wire  logic       clk,
  input  wire  logic       rst,
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  zcrm_stat_t stat,
  output zcrm_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_RPM_WAIT = 3'd2;
  localparam logic [2:0] S_SUM      = 3'd3;
  localparam logic [2:0] S_AVG_GO   = 3'd4;
  localparam logic [2:0] S_AVG_WAIT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and advance
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.crossing) begin
          cmd.div_rpm = 1'b1;
          state_next  = S_RPM_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RPM_WAIT: begin
        if (stat.div_done) begin
          cmd.store_rpm = 1'b1;
          state_next    = stat.multi ? S_SUM : S_DONE;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.sum_last) begin
          state_next = S_AVG_GO;
        end
      end
      S_AVG_GO: begin
        cmd.div_avg = 1'b1;
        state_next  = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (stat.div_done) begin
          cmd.store_avg = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/zcrm_checker.sv */
`default_nettype none
module zcrm_checker import zcrm_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [RPM_W-1:0] rpm,
  input wire logic [RPM_W-1:0] rpm_average,
  input wire logic             crossing,
  input wire logic             zero_interval
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rpm) && $stable(rpm_average)
      && $stable(crossing) && $stable(zero_interval))
    else $error("result changed while stalled");

  // No crossing means no average and no zero interval
  a_no_cross: assert property (@(posedge clk) disable iff (rst)
    out_valid && !crossing |-> rpm_average == '0 && !zero_interval)
    else $error("average or zero flag without crossing");

  // A zero interval is counted as one millisecond
  a_zero_iv: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_interval |-> rpm == RPM_W'(RPM_NUM))
    else $error("zero interval with wrong rpm");

  // The mean never exceeds the largest possible rpm
  a_avg_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rpm_average <= RPM_W'(RPM_NUM))
    else $error("average out of range");

endmodule

bind zero_cross_rpm_meter_top zcrm_checker u_chk (.*);
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import zcrm_pkg::*;

  localparam int CENTER     = 2048;
  localparam int LONG_STALL = 300;
  localparam int PHASES     = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic [TIME_W-1:0]   t;
  } tach_req_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [RPM_W-1:0] rpm_average;
    logic             crossing;
    logic             zero_interval;
  } tach_reading_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [LEN_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic [TIME_W-1:0]   now_ms = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RPM_W-1:0]    rpm;
  logic [RPM_W-1:0]    rpm_average;
  logic                crossing;
  logic                zero_interval;

  // Tachometer shadow state
  int               last_centered = 0;
  logic [TIME_W-1:0] last_cross_ms = '0;
  logic [RPM_W-1:0] rpm_hist [HISTORY_DEPTH];
  logic [LEN_W-1:0] hist_len_shadow = LEN_W'(LEN_RESET);

  tach_req_t     pending_samples[$];
  tach_reading_t expected_readings[$];

  int          mismatch_count = 0;
  int          tx_gap = 0;
  int          rx_wait = 0;
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  bit          long_stall_arm = 1'b0;
  bit          long_stall_done = 1'b0;
  bit          gen_positive = 1'b0;
  logic [TIME_W-1:0] gen_time = '0;

  zero_cross_rpm_meter_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rpm          (rpm),
    .rpm_average  (rpm_average),
    .crossing     (crossing),
    .zero_interval(zero_interval)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  function automatic int draw_wait(input bit quiet);
    if (quiet) return 0;
    return int'($urandom_range(0, 7));
  endfunction

  // Advance the shadow tachometer by one sample and return its reading
  function automatic tach_reading_t tach_predict(input logic [SAMPLE_W-1:0] smp,
                                                 input logic [TIME_W-1:0] t);
    tach_reading_t r;
    int cur;
    int n;
    logic [TIME_W-1:0] delta;
    int unsigned acc;
    r = '0;
    cur = int'(smp) - CENTER;
    if ((cur > 1 && last_centered < -1) || (cur < -1 && last_centered > 1)) begin
      delta = t - last_cross_ms;
      last_cross_ms = t;
      r.crossing = 1'b1;
      // zero interval counts as one
      if (delta == 0) begin
        delta = 1;
        r.zero_interval = 1'b1;
      end
      rpm_hist[0] = RPM_W'(32'(RPM_NUM) / delta);
      n = int'(hist_len_shadow);
      if (n < 1) n = 1;
      if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
      if (n > 1) begin
        acc = 0;
        for (int i = n - 1; i >= 1; i--) begin
          rpm_hist[i] = rpm_hist[i - 1];
          acc += rpm_hist[i];
        end
        r.rpm_average = RPM_W'(acc / (n - 1));
      end
    end
    last_centered = cur;
    r.rpm = rpm_hist[0];
    return r;
  endfunction

  task automatic queue_sample(input int smp, input logic [TIME_W-1:0] t);
    tach_req_t req;
    req.smp = SAMPLE_W'(smp);
    req.t = t;
    pending_samples.push_back(req);
  endtask

  // Mostly alternating waveforms with random timing, plus deadband and noise
  task automatic queue_random(input int count);
    tach_req_t req;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 9) < 6) gen_positive = !gen_positive;
        req.smp = gen_positive ? SAMPLE_W'($urandom_range(2050, 4095))
                               : SAMPLE_W'($urandom_range(0, 2046));
      end else if (pick < 82) begin
        req.smp = SAMPLE_W'($urandom_range(2047, 2049));
      end else begin
        req.smp = SAMPLE_W'($urandom_range(0, 4095));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // same timestamp, zero interval on a crossing
      end else if (pick < 65) begin
        gen_time += $urandom_range(1, 60);
      end else if (pick < 88) begin
        gen_time += $urandom_range(61, 40000);
      end else begin
        gen_time = $urandom;
      end
      req.t = gen_time;
      pending_samples.push_back(req);
    end
  endtask

  // Hold until every request is taken and every reading has come back
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_history_len(input int v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= LEN_W'(v);
    hist_len_shadow = LEN_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Request driver
  always @(posedge clk) begin
    tach_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_readings.push_back(tach_predict(sample, now_ms));
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_samples.size() != 0) begin
        req = pending_samples.pop_front();
        sample <= req.smp;
        now_ms <= req.t;
        in_valid <= 1'b1;
        tx_gap <= draw_wait(quiet_tx);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reading monitor and receiver stalls
  always @(posedge clk) begin
    tach_reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      long_stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("reading with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (rpm !== want.rpm) begin
            $error("rpm: expected %0d, actual %0d", want.rpm, rpm);
            mismatch_count++;
          end
          if (rpm_average !== want.rpm_average) begin
            $error("rpm_average: expected %0d, actual %0d", want.rpm_average, rpm_average);
            mismatch_count++;
          end
          if (crossing !== want.crossing) begin
            $error("crossing: expected %0d, actual %0d", want.crossing, crossing);
            mismatch_count++;
          end
          if (zero_interval !== want.zero_interval) begin
            $error("zero_interval: expected %0d, actual %0d", want.zero_interval,
                   zero_interval);
            mismatch_count++;
          end
        end
        if (long_stall_arm && !long_stall_done) begin
          long_stall_done <= 1'b1;
          rx_wait <= LONG_STALL;
          out_ready <= 1'b0;
        end else begin
          rx_wait <= draw_wait(quiet_rx);
          out_ready <= 1'b0;
        end
      end else if (rx_wait != 0) begin
        out_ready <= 1'b0;
        rx_wait <= rx_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int lens [PHASES];
    lens = '{32, 63, 0, 3, 1, 33, 16, 2, 31, 0};
    for (int i = 0; i < HISTORY_DEPTH; i++) rpm_hist[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset history length: no averaging
    queue_sample(2048, 0);
    queue_sample(4095, 5);              // previous sample at center
    queue_sample(0, 5);                 // crossing, interval 5
    queue_sample(4095, 5);              // zero interval
    queue_sample(2049, 6);              // inside deadband
    queue_sample(0, 7);
    queue_sample(2047, 7);
    queue_sample(4095, 8);
    queue_sample(2046, 10);
    queue_sample(2050, 11);             // interval 1, full scale rpm
    queue_sample(2046, 30012);          // interval above numerator, rpm 0
    queue_sample(4095, 60012);
    queue_sample(0, 32'hFFFF_FFF0);
    queue_sample(4095, 32'h0000_0010);  // timestamp wrap
    queue_sample(0, 32'hFFFF_FFFF);
    wait_idle();

    // shortest averaging window
    set_history_len(2);
    queue_sample(4095, 100);
    queue_sample(0, 103);
    queue_sample(4095, 103);
    queue_sample(0, 110);
    queue_sample(2048, 111);
    queue_sample(4095, 200);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      quiet_tx = (ph % 3 == 1);
      quiet_rx = (ph % 4 == 2);
      long_stall_arm = (ph == 0);
      set_history_len(ph == PHASES - 1 ? int'($urandom_range(0, 63)) : lens[ph]);
      queue_random(110);
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/zcrm_pkg.sv
rtl/core/zcrm_div.sv
rtl/core/zcrm_datapath.sv
rtl/core/zcrm_ctrl.sv
rtl/core/zero_cross_rpm_meter_top.sv
rtl/core/zcrm_checker.sv
tb/sv/tb_top.sv
